FILE: design/gyro_bias_calibrate_integrate_assert.svh
// Assertion macros shared by the RTL of the gyro bias calibrator.
// Each macro checks one property on the rising edge of clk, disabled in reset.
`ifndef GYRO_BIAS_CALIBRATE_INTEGRATE_ASSERT_SVH
`define GYRO_BIAS_CALIBRATE_INTEGRATE_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define GBCI_ASSERT_IMPLY(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("gbci: same-cycle check failed");

// Next-cycle implication.
`define GBCI_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("gbci: next-cycle check failed");

`else

`define GBCI_ASSERT_IMPLY(name, ante, cons)
`define GBCI_ASSERT_NEXT(name, ante, cons)

`endif

`endif

FILE: design/gbci_pkg.sv
package gbci_pkg;

  // Reset values of the configuration registers.
  localparam logic [31:0] WARMUP_RESET    = 32'd5000000;
  localparam logic [31:0] CALIB_END_RESET = 32'd15000000;

  // Configuration register indexes.
  localparam logic CFG_WARMUP    = 1'b0;
  localparam logic CFG_CALIB_END = 1'b1;

  // Phase codes reported with each result.
  localparam logic [1:0] PH_WARMUP = 2'd0;
  localparam logic [1:0] PH_CALIB  = 2'd1;
  localparam logic [1:0] PH_INTEG  = 2'd2;

  // Saturation limits.
  localparam logic [47:0] ACC48_MAX = {1'b0, {47{1'b1}}};
  localparam logic [47:0] ACC48_MIN = {1'b1, {47{1'b0}}};
  localparam logic [63:0] ACC64_MAX = {1'b0, {63{1'b1}}};
  localparam logic [63:0] ACC64_MIN = {1'b1, {63{1'b0}}};
  localparam logic [31:0] EST_MAX   = {1'b0, {31{1'b1}}};
  localparam logic [31:0] EST_MIN   = {1'b1, {31{1'b0}}};

  // Status of a serial arithmetic unit.
  typedef struct packed {
    logic busy;
    logic done;
  } gbci_unit_stat_t;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_TIME,
    S_PHASE,
    S_MLOAD,
    S_MUL,
    S_BACC,
    S_DLOAD,
    S_DIV,
    S_DFIN,
    S_ICLAMP,
    S_IADD,
    S_OUT
  } gbci_state_t;

endpackage

FILE: design/gyro_bias_calibrate_integrate.sv
// Channel  | Direction | Ports
// ---------+-----------+-------------------------------------------------------------
// input    | in        | in_valid, in_stall, in_response_word, in_elapsed_ticks, in_clear
// result   | out       | out_valid, out_stall, out_rate_q16, out_angle_acc,
//          |           | out_offset_q16, out_phase
// config   | in        | cfg_we, cfg_index, cfg_wdata
//
// One beat is worked on at a time; in_stall is low only while the sequencer is idle.
// Accept to result: clear beats go from S_TIME to S_OUT, warmup beats pass S_PHASE,
// integrating beats also the serial multiplier, S_ICLAMP and S_IADD, calibrating
// beats the multiplier, S_BACC and the 64-step serial divider; S_OUT waits while
// out_stall holds the output register, then returns to idle. Reset is synchronous.
// A finished result waits in the output register while the next beat is accepted.
`include "gyro_bias_calibrate_integrate_assert.svh"

module gyro_bias_calibrate_integrate
  import gbci_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,

  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_wdata,

  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_response_word,
  input  logic [19:0] in_elapsed_ticks,
  input  logic        in_clear,

  output logic        out_valid,
  input  logic        out_stall,
  output logic signed [32:0] out_rate_q16,
  output logic signed [63:0] out_angle_acc,
  output logic signed [31:0] out_offset_q16,
  output logic [1:0]  out_phase
);

  gbci_state_t state_r;
  gbci_state_t state_nxt;

  // Configuration registers.
  logic [31:0] warm_r;
  logic [31:0] cal_r;

  // Accepted beat.
  logic [31:0] word_r;
  logic [19:0] elapsed_r;
  logic        clear_r;

  // Running state.
  logic [31:0] total_r;
  logic [31:0] tsu_r;
  logic [47:0] bacc_r;
  logic [31:0] est_r;
  logic [32:0] corr_r;
  logic [63:0] angle_r;
  logic [1:0]  phase_r;
  logic [31:0] dt_r;
  logic        neg_r;
  logic [63:0] inc_r;

  logic        out_valid_r;

  // Sequencer outputs.
  logic mul_start;
  logic div_start;
  logic out_load;

  gbci_unit_stat_t mul_stat;
  gbci_unit_stat_t div_stat;
  logic [63:0]     mul_prod;
  logic [63:0]     div_quot;

  // Derived datapath values.
  logic [15:0] raw;
  logic [32:0] total_sum;
  logic [32:0] tsu_sum;
  logic        started;
  logic [1:0]  ph_new;
  logic [32:0] mul_src;
  logic [32:0] mcand;
  logic [48:0] bacc_sum;
  logic [63:0] dvd_q16;
  logic [63:0] dividend;
  logic [64:0] angle_sum;

  // Raw rate: word bits 25:24, 23:16 and 15:10, most significant first.
  assign raw = {word_r[25:24], word_r[23:16], word_r[15:10]};

  // Saturating tick sums.
  assign total_sum = {1'b0, total_r} + {13'd0, elapsed_r};
  assign tsu_sum   = {1'b0, tsu_r} + {13'd0, elapsed_r};
  assign started   = total_r >= warm_r;

  // Phase picked from the updated tick total.
  always_comb begin
    if (total_r < warm_r) begin
      ph_new = PH_WARMUP;
    end else if (total_r < cal_r) begin
      ph_new = PH_CALIB;
    end else begin
      ph_new = PH_INTEG;
    end
  end

  // Multiplicand magnitude: the raw rate while calibrating, the corrected rate after.
  assign mul_src = (phase_r == PH_CALIB) ? {{17{raw[15]}}, raw} : corr_r;
  assign mcand   = mul_src[32] ? (~mul_src + 33'd1) : mul_src;

  // Signed product added into the bias accumulator in one adder with carry in.
  assign bacc_sum = {bacc_r[47], bacc_r}
                  + (neg_r ? ~{1'b0, mul_prod[47:0]} : {1'b0, mul_prod[47:0]})
                  + {48'd0, neg_r};

  // Dividend magnitude of the accumulator scaled by two to the sixteenth.
  assign dvd_q16  = {bacc_r, 16'h0000};
  assign dividend = bacc_r[47] ? (~dvd_q16 + 64'd1) : dvd_q16;

  assign angle_sum = {angle_r[63], angle_r} + {inc_r[63], inc_r};

  gbci_mul u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_start),
    .mcand   (mcand),
    .mplier  (dt_r),
    .stat    (mul_stat),
    .product (mul_prod)
  );

  gbci_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (total_r),
    .stat     (div_stat),
    .quotient (div_quot)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:   if (in_valid) state_nxt = S_TIME;
      S_TIME:   state_nxt = clear_r ? S_OUT : S_PHASE;
      S_PHASE:  state_nxt = (ph_new == PH_WARMUP) ? S_OUT : S_MLOAD;
      S_MLOAD:  state_nxt = S_MUL;
      S_MUL: begin
        if (mul_stat.done) begin
          state_nxt = (phase_r == PH_CALIB) ? S_BACC : S_ICLAMP;
        end
      end
      S_BACC:   state_nxt = (total_r != 32'd0) ? S_DLOAD : S_OUT;
      S_DLOAD:  state_nxt = S_DIV;
      S_DIV:    if (div_stat.done) state_nxt = S_DFIN;
      S_DFIN:   state_nxt = S_OUT;
      S_ICLAMP: state_nxt = S_IADD;
      S_IADD:   state_nxt = S_OUT;
      S_OUT:    if (!out_valid_r || !out_stall) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_stall  = (state_r != S_IDLE);
    mul_start = (state_r == S_MLOAD);
    div_start = (state_r == S_DLOAD);
    out_load  = (state_r == S_OUT) && (!out_valid_r || !out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Capture the accepted beat.
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_valid) begin
      word_r    <= in_response_word;
      elapsed_r <= in_elapsed_ticks;
      clear_r   <= in_clear;
    end
  end

  // Configuration registers and the running state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      warm_r      <= WARMUP_RESET;
      cal_r       <= CALIB_END_RESET;
      total_r     <= '0;
      tsu_r       <= '0;
      bacc_r      <= '0;
      est_r       <= '0;
      corr_r      <= '0;
      angle_r     <= '0;
      phase_r     <= PH_WARMUP;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_WARMUP:    warm_r <= cfg_wdata;
          CFG_CALIB_END: cal_r  <= cfg_wdata;
          default:       warm_r <= warm_r;
        endcase
      end

      case (state_r)
        // Clear, or advance the total timer and, once warmup is over, the interval timer.
        S_TIME: begin
          if (clear_r) begin
            total_r <= '0;
            tsu_r   <= '0;
            bacc_r  <= '0;
            est_r   <= '0;
            corr_r  <= '0;
            angle_r <= '0;
            phase_r <= PH_WARMUP;
          end else begin
            total_r <= total_sum[32] ? '1 : total_sum[31:0];
            if (started) begin
              tsu_r <= tsu_sum[32] ? '1 : tsu_sum[31:0];
            end
          end
        end
        // A used sample takes the interval and restarts the interval timer.
        S_PHASE: begin
          phase_r <= ph_new;
          if (ph_new != PH_WARMUP) begin
            dt_r  <= tsu_r;
            tsu_r <= '0;
          end
          if (ph_new == PH_INTEG) begin
            corr_r <= {raw[15], raw, 16'h0000} - {est_r[31], est_r};
          end
        end
        S_MLOAD: neg_r <= mul_src[32];
        // Saturating bias accumulation.
        S_BACC: begin
          if (bacc_sum[48] != bacc_sum[47]) begin
            bacc_r <= bacc_sum[48] ? ACC48_MIN : ACC48_MAX;
          end else begin
            bacc_r <= bacc_sum[47:0];
          end
        end
        // Signed, saturated quotient becomes the bias estimate.
        S_DFIN: begin
          if (bacc_r[47]) begin
            est_r <= (div_quot > 64'h0000_0000_8000_0000) ? EST_MIN : (~div_quot[31:0] + 32'd1);
          end else begin
            est_r <= (div_quot > 64'h0000_0000_7FFF_FFFF) ? EST_MAX : div_quot[31:0];
          end
        end
        // Clamp the signed rate-times-interval product to 64 bits.
        S_ICLAMP: begin
          if (!neg_r) begin
            inc_r <= mul_prod[63] ? ACC64_MAX : mul_prod;
          end else if (mul_prod[63] && (|mul_prod[62:0])) begin
            inc_r <= ACC64_MIN;
          end else begin
            inc_r <= ~mul_prod + 64'd1;
          end
        end
        // Saturating angle accumulation.
        S_IADD: begin
          if (angle_sum[64] != angle_sum[63]) begin
            angle_r <= angle_sum[64] ? ACC64_MIN : ACC64_MAX;
          end else begin
            angle_r <= angle_sum[63:0];
          end
        end
        default: phase_r <= phase_r;
      endcase

      // Output beat handshake.
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_rate_q16   <= corr_r;
      out_angle_acc  <= angle_r;
      out_offset_q16 <= est_r;
      out_phase      <= phase_r;
    end
  end

  assign out_valid = out_valid_r;

  // The serial units only report completion while the sequencer waits on them.
  `GBCI_ASSERT_IMPLY(a_mul_done_waited, mul_stat.done, state_r == S_MUL)
  `GBCI_ASSERT_IMPLY(a_div_done_waited, div_stat.done, state_r == S_DIV)
  // No beat is taken while an arithmetic unit is running.
  `GBCI_ASSERT_IMPLY(a_busy_stalls, mul_stat.busy || div_stat.busy, in_stall)
  // A loaded result carries the phase computed for it.
  `GBCI_ASSERT_NEXT(a_out_phase, out_load, out_valid && out_phase == $past(phase_r))

endmodule

FILE: design/gbci_mul.sv
// Serial shift-add multiplier: one multiplier bit per cycle, 33 x 32 unsigned.
module gbci_mul
  import gbci_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [32:0]     mcand,
  input  logic [31:0]     mplier,
  output gbci_unit_stat_t stat,
  output logic [63:0]     product
);

  localparam logic [4:0] LAST_STEP = 5'd31;

  logic        busy_r;
  logic        done_r;
  logic [4:0]  cnt_r;
  logic [32:0] mcand_r;
  logic [32:0] hi_r;
  logic [31:0] lo_r;
  logic [33:0] sum;

  // Partial product add for the multiplier bit that leaves the low register.
  assign sum = {1'b0, hi_r} + (lo_r[0] ? {1'b0, mcand_r} : 34'd0);

  // Control: count the steps and pulse done after the last one.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == LAST_STEP) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath: the product shifts right one bit per step.
  always_ff @(posedge clk) begin
    if (start) begin
      mcand_r <= mcand;
      hi_r    <= '0;
      lo_r    <= mplier;
    end else if (busy_r) begin
      hi_r <= sum[33:1];
      lo_r <= {sum[0], lo_r[31:1]};
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign product   = {hi_r[31:0], lo_r};

endmodule

FILE: design/gbci_div.sv
// Restoring divider: one quotient bit per cycle, 64 / 32 unsigned.
module gbci_div
  import gbci_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [63:0]     dividend,
  input  logic [31:0]     divisor,
  output gbci_unit_stat_t stat,
  output logic [63:0]     quotient
);

  localparam logic [5:0] LAST_STEP = 6'd63;

  logic        busy_r;
  logic        done_r;
  logic [5:0]  cnt_r;
  logic [31:0] dvs_r;
  logic [31:0] rem_r;
  logic [63:0] q_r;
  logic [32:0] shifted;
  logic [33:0] diff;
  logic        qbit;

  // Trial subtract of the divisor from the shifted partial remainder.
  assign shifted = {rem_r, q_r[63]};
  assign diff    = {1'b0, shifted} - {2'b00, dvs_r};
  assign qbit    = ~diff[33];

  // Control: count the steps and pulse done after the last one.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == LAST_STEP) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath: dividend bits shift out of the top as quotient bits shift in.
  always_ff @(posedge clk) begin
    if (start) begin
      dvs_r <= divisor;
      rem_r <= '0;
      q_r   <= dividend;
    end else if (busy_r) begin
      rem_r <= qbit ? diff[31:0] : shifted[31:0];
      q_r   <= {q_r[62:0], qbit};
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = q_r;

endmodule
